// File: sv/lfmr_pkg.sv
// Shared types and constants for the length-framed message ring.
// Used by lfmr_front, lfmr_back and length_framed_message_ring_top.
package lfmr_pkg;

    localparam int RING_BYTES   = 4096;
    localparam int RING_IDX_W   = $clog2(RING_BYTES);
    localparam int PTR_W        = 17;
    localparam int HEADER_BYTES = 4;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int HDR_CNT_W    = $clog2(HEADER_BYTES + 1);
    localparam int LEN_W        = 16;
    localparam int FLEN_W       = 32;
    localparam int BYTE_W       = 8;

    localparam logic [LEN_W-1:0] MAX_MSG_RESET = 16'd4092;

    // APB byte address of max_message_bytes
    localparam logic [2:0] ADDR_MAX_MSG = 3'd0;

    typedef enum logic [1:0] {
        OP_SEND_OPEN = 2'd0,
        OP_SEND_BYTE = 2'd1,
        OP_RECV_OPEN = 2'd2,
        OP_RECV_BYTE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RING_FULL = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_NOTHING   = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_TOO_SMALL = 3'd5,
        ST_SEQ_ERROR = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HDR_WR,
        BK_HDR_RD,
        BK_HDR_EVAL,
        BK_RD_BYTE
    } back_state_t;

    // classified item: length is msg_length for send_open, buffer_capacity otherwise
    typedef struct packed {
        op_t               op;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [FLEN_W-1:0] frame_length;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic [PTR_W-1:0]  pending;
    } result_t;

endpackage

// File: sv/length_framed_message_ring_top.sv
// Top level of the length-framed message ring: stream ports, APB register, front and back.
// Depends on lfmr_pkg, lfmr_front and lfmr_back.

// A 4096-byte ring that carries whole messages, each behind a 4-byte
// little-endian length header. Every item gives exactly one result. Items
// enter a two-deep queue and are carried out one at a time by a sequencer
// around a single-port ring memory with a registered read; an item is taken
// only when the result register is empty or being read out. send_byte, an
// out-of-sequence item, a refused send_open and a recv_open with nothing pending
// are answered in the cycle of the pop; recv_byte also waits for the memory read; an
// accepted send_open pops, then writes one header byte per cycle; a recv_open
// that finds a header pending pops, reads the header through the read register,
// then makes the length checks.
// No clearing pass after reset.
module length_framed_message_ring_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // msg_length[15:0], buffer_capacity[31:16], in_byte[39:32]
    input  logic [1:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // frame_length[31:0], out_byte[39:32], pending_bytes[56:40]
    output logic [2:0]  m_axis_tuser,  // status
    output logic        m_axis_tlast,  // last_byte
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [lfmr_pkg::LEN_W-1:0] max_msg_reg, max_msg_next;
    logic                       item_valid;
    lfmr_pkg::item_t            item;
    logic                       item_pop;
    lfmr_pkg::result_t          res;

    assign pready = 1'b1;

    always_comb
    begin
        max_msg_next = max_msg_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == lfmr_pkg::ADDR_MAX_MSG[2]))
        begin
            max_msg_next = pwdata[lfmr_pkg::LEN_W-1:0];
        end
        if (paddr[2] == lfmr_pkg::ADDR_MAX_MSG[2])
        begin
            prdata = {{(32-lfmr_pkg::LEN_W){1'b0}}, max_msg_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_msg_reg <= lfmr_pkg::MAX_MSG_RESET;
        end
        else
        begin
            max_msg_reg <= max_msg_next;
        end
    end

    lfmr_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    lfmr_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item              (item),
        .item_pop          (item_pop),
        .max_message_bytes (max_msg_reg),
        .res_valid         (m_axis_tvalid),
        .res               (res),
        .res_ready         (m_axis_tready)
    );

    assign m_axis_tdata = {7'b0, res.pending, res.out_byte, res.frame_length};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;

endmodule

// File: sv/lfmr_front.sv
// Front end: accepts stream items, classifies them and queues them.
// Depends on lfmr_pkg.
module lfmr_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [39:0]            s_axis_tdata,  // msg_length, buffer_capacity, in_byte
    input  logic [1:0]             s_axis_tuser,  // operation
    output logic                   item_valid,
    output lfmr_pkg::item_t        item,
    input  logic                   item_pop
);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    lfmr_pkg::item_t   queue_reg [QUEUE_DEPTH];
    lfmr_pkg::item_t   in_item;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    always_comb
    begin
        in_item.op   = lfmr_pkg::op_t'(s_axis_tuser);
        in_item.data = s_axis_tdata[39:32];
        if (lfmr_pkg::op_t'(s_axis_tuser) == lfmr_pkg::OP_SEND_OPEN)
        begin
            in_item.length = s_axis_tdata[15:0];
        end
        else
        begin
            in_item.length = s_axis_tdata[31:16];
        end
    end

    assign s_axis_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign item_valid    = (count_reg != '0);
    assign pop           = item_pop && item_valid;
    assign item          = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: sv/lfmr_back.sv
// Back end: ring memory, frame pointers and the sequencer that carries out items.
// Depends on lfmr_pkg.
module lfmr_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  lfmr_pkg::item_t                 item,
    output logic                            item_pop,
    input  logic [lfmr_pkg::LEN_W-1:0]      max_message_bytes,
    output logic                            res_valid,
    output lfmr_pkg::result_t               res,
    input  logic                            res_ready
);

    localparam int PW = lfmr_pkg::PTR_W;
    localparam int IW = lfmr_pkg::RING_IDX_W;
    localparam int CW = lfmr_pkg::HDR_CNT_W;

    logic [lfmr_pkg::BYTE_W-1:0] ring_mem [lfmr_pkg::RING_BYTES];
    logic [lfmr_pkg::BYTE_W-1:0] mem_rdata_reg;
    logic                        mem_we;
    logic [IW-1:0]               mem_addr;
    logic [lfmr_pkg::BYTE_W-1:0] mem_wdata;

    lfmr_pkg::back_state_t state_reg, state_next;
    lfmr_pkg::item_t       cur_reg, cur_next;
    lfmr_pkg::result_t     res_reg, res_d;
    logic                  out_valid_reg, out_valid_next;
    logic                  res_load;

    logic [PW-1:0]                rp_reg, rp_next;
    logic [PW-1:0]                wp_reg, wp_next;
    logic [PW-1:0]                sc_reg, sc_next;
    logic [lfmr_pkg::LEN_W-1:0]   sl_reg, sl_next;
    logic                         sa_reg, sa_next;
    logic [PW-1:0]                rc_reg, rc_next;
    logic [lfmr_pkg::LEN_W-1:0]   rl_reg, rl_next;
    logic                         ra_reg, ra_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [lfmr_pkg::FLEN_W-1:0]  hdr_reg, hdr_next;

    logic [PW-1:0]                pending;
    logic [PW:0]                  room_sum;
    logic [lfmr_pkg::FLEN_W-1:0]  hdr_word;
    logic [PW-1:0]                wp_k;
    logic [PW-1:0]                rp_k;
    logic                         truncated;

    assign pending   = wp_reg - rp_reg;
    assign room_sum  = (PW+1)'(pending) + (PW+1)'(lfmr_pkg::HEADER_BYTES)
                     + (PW+1)'(item.length);
    assign hdr_word  = {{(lfmr_pkg::FLEN_W-lfmr_pkg::LEN_W){1'b0}}, cur_reg.length};
    assign wp_k      = wp_reg + PW'(cnt_reg);
    assign rp_k      = rp_reg + PW'(cnt_reg);
    assign truncated = {{(lfmr_pkg::FLEN_W+1-PW){1'b0}}, pending}
                     < ((lfmr_pkg::FLEN_W+1)'(lfmr_pkg::HEADER_BYTES) + {1'b0, hdr_reg});

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        sc_next    = sc_reg;
        sl_next    = sl_reg;
        sa_next    = sa_reg;
        rc_next    = rc_reg;
        rl_next    = rl_reg;
        ra_next    = ra_reg;
        cnt_next   = cnt_reg;
        hdr_next   = hdr_reg;
        mem_we     = 1'b0;
        mem_addr   = rp_reg[IW-1:0];
        mem_wdata  = '0;
        item_pop   = 1'b0;
        res_load   = 1'b0;
        res_d      = '0;
        res_d.status = lfmr_pkg::ST_OK;

        unique case (state_reg)
            lfmr_pkg::BK_IDLE:
            begin
                if (item_valid && (!out_valid_reg || res_ready))
                begin
                    item_pop = 1'b1;
                    cur_next = item;
                    unique case (item.op)
                        lfmr_pkg::OP_SEND_OPEN:
                        begin
                            if (sa_reg)
                            begin
                                res_load     = 1'b1;
                                res_d.status = lfmr_pkg::ST_SEQ_ERROR;
                            end
                            else if (item.length > max_message_bytes)
                            begin
                                res_load     = 1'b1;
                                res_d.status = lfmr_pkg::ST_TOO_LONG;
                            end
                            else if (room_sum > (PW+1)'(lfmr_pkg::RING_BYTES))
                            begin
                                res_load     = 1'b1;
                                res_d.status = lfmr_pkg::ST_RING_FULL;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                state_next = lfmr_pkg::BK_HDR_WR;
                            end
                        end
                        lfmr_pkg::OP_SEND_BYTE:
                        begin
                            res_load = 1'b1;
                            if (!sa_reg)
                            begin
                                res_d.status = lfmr_pkg::ST_SEQ_ERROR;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_addr  = sc_reg[IW-1:0];
                                mem_wdata = item.data;
                                sc_next   = sc_reg + 1'b1;
                                sl_next   = sl_reg - 1'b1;
                                if (sl_reg == lfmr_pkg::LEN_W'(1))
                                begin
                                    wp_next    = sc_reg + 1'b1;
                                    sa_next    = 1'b0;
                                    res_d.last = 1'b1;
                                end
                            end
                        end
                        lfmr_pkg::OP_RECV_OPEN:
                        begin
                            if (ra_reg)
                            begin
                                res_load     = 1'b1;
                                res_d.status = lfmr_pkg::ST_SEQ_ERROR;
                            end
                            else if (pending < PW'(lfmr_pkg::HEADER_BYTES))
                            begin
                                res_load     = 1'b1;
                                res_d.status = lfmr_pkg::ST_NOTHING;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                state_next = lfmr_pkg::BK_HDR_RD;
                            end
                        end
                        lfmr_pkg::OP_RECV_BYTE:
                        begin
                            if (!ra_reg)
                            begin
                                res_load     = 1'b1;
                                res_d.status = lfmr_pkg::ST_SEQ_ERROR;
                            end
                            else
                            begin
                                mem_addr   = rc_reg[IW-1:0];
                                state_next = lfmr_pkg::BK_RD_BYTE;
                            end
                        end
                        default:
                        begin
                            res_load     = 1'b1;
                            res_d.status = lfmr_pkg::ST_SEQ_ERROR;
                        end
                    endcase
                end
            end
            lfmr_pkg::BK_HDR_WR:
            begin
                mem_we    = 1'b1;
                mem_addr  = wp_k[IW-1:0];
                mem_wdata = hdr_word[{cnt_reg[lfmr_pkg::HDR_IDX_W-1:0], 3'b000} +: 8];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(lfmr_pkg::HEADER_BYTES - 1))
                begin
                    res_load   = 1'b1;
                    state_next = lfmr_pkg::BK_IDLE;
                    sc_next    = wp_reg + PW'(lfmr_pkg::HEADER_BYTES);
                    if (cur_reg.length == '0)
                    begin
                        wp_next    = wp_reg + PW'(lfmr_pkg::HEADER_BYTES);
                        res_d.last = 1'b1;
                    end
                    else
                    begin
                        sl_next = cur_reg.length;
                        sa_next = 1'b1;
                    end
                end
            end
            lfmr_pkg::BK_HDR_RD:
            begin
                mem_addr = rp_k[IW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0)
                begin
                    hdr_next = {mem_rdata_reg, hdr_reg[lfmr_pkg::FLEN_W-1:lfmr_pkg::BYTE_W]};
                end
                if (cnt_reg == CW'(lfmr_pkg::HEADER_BYTES))
                begin
                    state_next = lfmr_pkg::BK_HDR_EVAL;
                end
            end
            lfmr_pkg::BK_HDR_EVAL:
            begin
                res_load           = 1'b1;
                res_d.frame_length = hdr_reg;
                state_next         = lfmr_pkg::BK_IDLE;
                if (truncated)
                begin
                    res_d.status = lfmr_pkg::ST_TRUNCATED;
                end
                else if (hdr_reg > {{(lfmr_pkg::FLEN_W-lfmr_pkg::LEN_W){1'b0}}, cur_reg.length})
                begin
                    res_d.status = lfmr_pkg::ST_TOO_SMALL;
                end
                else
                begin
                    rc_next = rp_reg + PW'(lfmr_pkg::HEADER_BYTES);
                    if (hdr_reg == '0)
                    begin
                        rp_next    = rp_reg + PW'(lfmr_pkg::HEADER_BYTES);
                        res_d.last = 1'b1;
                    end
                    else
                    begin
                        rl_next = hdr_reg[lfmr_pkg::LEN_W-1:0];
                        ra_next = 1'b1;
                    end
                end
            end
            lfmr_pkg::BK_RD_BYTE:
            begin
                res_load       = 1'b1;
                res_d.out_byte = mem_rdata_reg;
                state_next     = lfmr_pkg::BK_IDLE;
                rc_next        = rc_reg + 1'b1;
                rl_next        = rl_reg - 1'b1;
                if (rl_reg == lfmr_pkg::LEN_W'(1))
                begin
                    rp_next    = rc_reg + 1'b1;
                    ra_next    = 1'b0;
                    res_d.last = 1'b1;
                end
            end
            default:
            begin
                state_next = lfmr_pkg::BK_IDLE;
            end
        endcase

        res_d.pending = wp_next - rp_next;

        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfmr_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            rp_reg        <= '0;
            wp_reg        <= '0;
            sc_reg        <= '0;
            sl_reg        <= '0;
            sa_reg        <= 1'b0;
            rc_reg        <= '0;
            rl_reg        <= '0;
            ra_reg        <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            sc_reg        <= sc_next;
            sl_reg        <= sl_next;
            sa_reg        <= sa_next;
            rc_reg        <= rc_next;
            rl_reg        <= rl_next;
            ra_reg        <= ra_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        hdr_reg <= hdr_next;
        if (res_load)
        begin
            res_reg <= res_d;
        end
    end

    // single-port ring, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= ring_mem[mem_addr];
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

// File: verif/tb.sv
// Testbench for length_framed_message_ring_top: stream items in, one result per item out.
// Predicts each result from its own copy of the ring state; needs lfmr_pkg and the RTL only.
// Directed cases, then random frame traffic under several idle and limit settings.
module tb;
    import lfmr_pkg::*;

    localparam int         CYCLE_LIMIT  = 300000;
    localparam int         PRINT_LIMIT  = 40;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // msg_length[15:0], buffer_capacity[31:16], in_byte[39:32]
    logic [1:0]  s_axis_tuser;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // frame_length[31:0], out_byte[39:32], pending_bytes[56:40]
    logic [2:0]  m_axis_tuser;   // status
    logic        m_axis_tlast;   // last_byte
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // ring state as the block should hold it
    logic [BYTE_W-1:0] ring_copy [RING_BYTES];
    logic [PTR_W-1:0]  head_ptr  = '0;
    logic [PTR_W-1:0]  tail_ptr  = '0;
    logic [PTR_W-1:0]  tx_cursor = '0;
    logic [PTR_W-1:0]  rx_cursor = '0;
    logic [LEN_W-1:0]  tx_left   = '0;
    logic [LEN_W-1:0]  rx_left   = '0;
    logic [LEN_W-1:0]  max_len   = MAX_MSG_RESET;
    bit                tx_open   = 1'b0;
    bit                rx_open   = 1'b0;

    result_t predicted_results [$];
    int      mismatch_count = 0;
    int      result_count   = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      hold_left      = 0;

    length_framed_message_ring_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned ring_slot(input logic [PTR_W-1:0] p);
        return int'(p[RING_IDX_W-1:0]);
    endfunction

    function automatic logic [PTR_W-1:0] queued_bytes();
        return tail_ptr - head_ptr;
    endfunction

    function automatic result_t ring_result_for(input op_t op, input logic [LEN_W-1:0] len,
                                                input logic [LEN_W-1:0] cap,
                                                input logic [BYTE_W-1:0] din);
        result_t           r;
        logic [FLEN_W-1:0] hdr;
        logic [FLEN_W-1:0] len_word;
        int                k;
        r = '0;
        r.status = ST_OK;
        len_word = {16'b0, len};
        case (op)
            OP_SEND_OPEN:
            begin
                if (tx_open)
                    r.status = ST_SEQ_ERROR;
                else if (len > max_len)
                    r.status = ST_TOO_LONG;
                else if (int'(queued_bytes()) + HEADER_BYTES + int'(len) > RING_BYTES)
                    r.status = ST_RING_FULL;
                else
                begin
                    for (k = 0; k < HEADER_BYTES; k++)
                        ring_copy[ring_slot(PTR_W'(tail_ptr + k))] = len_word[8*k +: 8];
                    tx_cursor = PTR_W'(tail_ptr + HEADER_BYTES);
                    if (len == '0)
                    begin
                        tail_ptr = tx_cursor;
                        r.last = 1'b1;
                    end
                    else
                    begin
                        tx_left = len;
                        tx_open = 1'b1;
                    end
                end
            end
            OP_SEND_BYTE:
            begin
                if (!tx_open)
                    r.status = ST_SEQ_ERROR;
                else
                begin
                    ring_copy[ring_slot(tx_cursor)] = din;
                    tx_cursor++;
                    tx_left--;
                    if (tx_left == '0)
                    begin
                        tail_ptr = tx_cursor;
                        tx_open = 1'b0;
                        r.last = 1'b1;
                    end
                end
            end
            OP_RECV_OPEN:
            begin
                if (rx_open)
                    r.status = ST_SEQ_ERROR;
                else if (queued_bytes() < PTR_W'(HEADER_BYTES))
                    r.status = ST_NOTHING;
                else
                begin
                    for (k = 0; k < HEADER_BYTES; k++)
                        hdr[8*k +: 8] = ring_copy[ring_slot(PTR_W'(head_ptr + k))];
                    r.frame_length = hdr;
                    if (longint'(queued_bytes()) < longint'(HEADER_BYTES) + longint'(hdr))
                        r.status = ST_TRUNCATED;
                    else if (hdr > FLEN_W'(cap))
                        r.status = ST_TOO_SMALL;
                    else
                    begin
                        rx_cursor = PTR_W'(head_ptr + HEADER_BYTES);
                        if (hdr == '0)
                        begin
                            head_ptr = rx_cursor;
                            r.last = 1'b1;
                        end
                        else
                        begin
                            rx_left = hdr[LEN_W-1:0];
                            rx_open = 1'b1;
                        end
                    end
                end
            end
            OP_RECV_BYTE:
            begin
                if (!rx_open)
                    r.status = ST_SEQ_ERROR;
                else
                begin
                    r.out_byte = ring_copy[ring_slot(rx_cursor)];
                    rx_cursor++;
                    rx_left--;
                    if (rx_left == '0)
                    begin
                        head_ptr = rx_cursor;
                        rx_open = 1'b0;
                        r.last = 1'b1;
                    end
                end
            end
        endcase
        r.pending = queued_bytes();
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s", result_count, what);
    endtask

    task automatic check_result();
        result_t want;
        if (predicted_results.size() == 0)
        begin
            report_mismatch("result with no item outstanding");
            return;
        end
        want = predicted_results.pop_front();
        if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
        if (m_axis_tdata[31:0] !== want.frame_length)
            report_mismatch($sformatf("frame_length %0d, want %0d",
                                      m_axis_tdata[31:0], want.frame_length));
        if (m_axis_tdata[39:32] !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, want %h", m_axis_tdata[39:32], want.out_byte));
        if (m_axis_tdata[56:40] !== want.pending)
            report_mismatch($sformatf("pending %0d, want %0d", m_axis_tdata[56:40], want.pending));
        if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                check_result();
                result_count++;
            end
        end
    end

    // receiver: random stalls, or a counted hold-off when hold_left is set
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_item(input op_t op, input logic [LEN_W-1:0] len,
                             input logic [LEN_W-1:0] cap, input logic [BYTE_W-1:0] din);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {din, cap, len};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted_results.push_back(ring_result_for(op, len, cap, din));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic read_max_len(input logic [LEN_W-1:0] expected);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MAX_MSG;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {16'b0, expected})
            report_mismatch($sformatf("max_message_bytes reads %h, want %h", prdata, expected));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_max_len(input logic [LEN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_MSG;
        pwdata  <= {16'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        max_len = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        read_max_len(value);
    endtask

    task automatic test_sequence_errors();
        push_item(OP_SEND_BYTE, 16'h1234, 16'h5678, 8'hA5);
        push_item(OP_RECV_BYTE, '0, '0, '0);
        push_item(OP_RECV_OPEN, '0, 16'hFFFF, '0);
        push_item(OP_SEND_OPEN, 16'd2, '0, '0);
        push_item(OP_SEND_OPEN, 16'd0, '0, '0);
        push_item(OP_SEND_BYTE, '0, '0, 8'h00);
        push_item(OP_SEND_BYTE, '0, '0, 8'hFF);
        push_item(OP_RECV_OPEN, '0, 16'hFFFF, '0);
        push_item(OP_RECV_OPEN, '0, 16'hFFFF, '0);
        push_item(OP_RECV_BYTE, '0, '0, '0);
        push_item(OP_RECV_BYTE, '0, '0, '0);
        drain();
    endtask

    task automatic test_length_limits();
        push_item(OP_SEND_OPEN, 16'd4093, '0, '0);
        push_item(OP_SEND_OPEN, 16'd0, '0, '0);
        push_item(OP_RECV_OPEN, '0, 16'd0, '0);
        push_item(OP_SEND_OPEN, 16'd3, '0, '0);
        push_item(OP_SEND_BYTE, '0, '0, 8'h5A);
        push_item(OP_SEND_BYTE, '0, '0, 8'h80);
        push_item(OP_SEND_BYTE, '0, '0, 8'h01);
        push_item(OP_RECV_OPEN, '0, 16'd2, '0);
        push_item(OP_RECV_OPEN, '0, 16'd3, '0);
        push_item(OP_RECV_BYTE, '0, '0, '0);
        push_item(OP_RECV_BYTE, '0, '0, '0);
        push_item(OP_RECV_BYTE, '0, '0, '0);
        drain();
        write_max_len(16'hFFFF);
        push_item(OP_SEND_OPEN, 16'hFFFF, '0, '0);
        push_item(OP_SEND_OPEN, 16'd4093, '0, '0);
        drain();
        write_max_len(16'd0);
        push_item(OP_SEND_OPEN, 16'd1, '0, '0);
        push_item(OP_SEND_OPEN, 16'd0, '0, '0);
        drain();
    endtask

    // mostly well-formed frames with random content, some stray items
    task automatic run_frame_traffic(input int n_items, input int longest);
        int               roll;
        logic [31:0]      fill;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] cap;
        repeat (n_items)
        begin
            roll = $urandom_range(99);
            fill = $urandom();
            if (roll < 6)
            begin
                push_item(op_t'($urandom_range(3)), LEN_W'($urandom_range(65535, 4093)),
                          fill[15:0], fill[31:24]);
            end
            else if ((roll < 55 && queued_bytes() < PTR_W'(3000))
                     || (!rx_open && queued_bytes() < PTR_W'(HEADER_BYTES)))
            begin
                if (tx_open)
                    push_item(OP_SEND_BYTE, fill[15:0], fill[31:16], BYTE_W'($urandom()));
                else
                begin
                    roll = $urandom_range(99);
                    if (roll < 30)
                        len = '0;
                    else if (roll < 85)
                        len = LEN_W'($urandom_range(12, 1));
                    else
                        len = LEN_W'($urandom_range(longest, 13));
                    push_item(OP_SEND_OPEN, len, fill[15:0], fill[31:24]);
                end
            end
            else if (rx_open)
                push_item(OP_RECV_BYTE, fill[15:0], fill[31:16], fill[31:24]);
            else
            begin
                roll = $urandom_range(99);
                if (roll < 15)
                    cap = LEN_W'($urandom_range(15));
                else if (roll < 25)
                    cap = LEN_W'($urandom());
                else
                    cap = 16'hFFFF;
                push_item(OP_RECV_OPEN, fill[15:0], cap, fill[31:24]);
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_left = 400;
        run_frame_traffic(60, 12);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_SEND_OPEN;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= ADDR_MAX_MSG;
        pwdata        <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 32;
        recv_stall_pct = 74;
        read_max_len(MAX_MSG_RESET);
        test_sequence_errors();
        test_length_limits();
        write_max_len(MAX_MSG_RESET);
        run_frame_traffic(450, 60);

        send_idle_pct  = 74;
        recv_stall_pct = 32;
        write_max_len(16'd200);
        run_frame_traffic(450, 60);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_max_len(16'hFFFF);
        test_backpressure();
        run_frame_traffic(400, 60);
        write_max_len(MAX_MSG_RESET);

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
